// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted (active low).
`define ASSERT_CLK_RSTN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that must hold during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/wdiv_pkg.sv -----
// Types and constants shared by the wide divider modules.
`timescale 1ns / 1ps

package wdiv_pkg;

    // Width of one low field and one high field of an operand.
    localparam int unsigned LOW_W  = 64;
    localparam int unsigned HIGH_W = 32;
    localparam int unsigned SLICE_W = 32;
    // Full operand width; its top bit index is 3 * SLICE_W - 1.
    localparam int unsigned WORD_W = 3 * SLICE_W;
    localparam int unsigned WORD_MSB = 3 * SLICE_W - 1;

    // Control from the sequencer to the shift-subtract unit.
    typedef struct packed {
        logic load;    // capture new operands
        logic bypass;  // zero divisor: quotient zero, remainder is the dividend
        logic step;    // run one restoring step
    } step_ctrl_t;

endpackage

// ----- rtl/wdiv_unit.sv -----
// Shift-subtract unit of the divider: one restoring step per cycle while step is set.
`timescale 1ns / 1ps

module wdiv_unit
    import wdiv_pkg::*;
#(
    parameter int unsigned OPERAND_BITS = 96
) (
    input  logic                    aclk,
    input  step_ctrl_t              ctrl,
    input  logic [OPERAND_BITS-1:0] num,
    input  logic [OPERAND_BITS-1:0] den,
    output logic [OPERAND_BITS-1:0] quo,
    output logic [OPERAND_BITS-1:0] rem
);

    localparam int unsigned W = OPERAND_BITS;

    // The dividend shifts out of the top of qr_reg while quotient bits enter at the bottom.
    logic [W-1:0] qr_reg,  qr_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] den_reg, den_next;

    logic [W:0]   partial;
    logic [W:0]   diff;
    logic         fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign partial = {rem_reg, qr_reg[W-1]};
    assign diff    = partial - {1'b0, den_reg};
    assign fits    = ~diff[W];

    always_comb begin
        qr_next  = qr_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (ctrl.load) begin
            den_next = den;
            if (ctrl.bypass) begin
                qr_next  = '0;
                rem_next = num;
            end else begin
                qr_next  = num;
                rem_next = '0;
            end
        end else if (ctrl.step) begin
            // Keep the difference only when it did not go negative.
            qr_next  = {qr_reg[W-2:0], fits};
            rem_next = fits ? diff[W-1:0] : partial[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo = qr_reg;
    assign rem = rem_reg;

endmodule

// ----- rtl/wide_unsigned_restoring_divider.sv -----
// Top level of the 96-bit unsigned restoring divider.
//
//  Channel  | Dir | Payload (lowest bits first)
//  ---------+-----+-------------------------------------------------------------
//  s_       | in  | tdata: dividend_low, dividend_high, divisor_low, divisor_high
//  m_       | out | tdata: quotient_low/high, remainder_low/high; tuser: div by 0
//
// A word is taken only while the block is idle. A division computes its result
// one quotient bit per cycle and then offers it; a zero divisor offers it on the
// next cycle. The result holds in place until the master side takes it, and the
// block is ready again on the cycle after, so a new word is taken only once the
// last result has gone. Reset returns the sequencer to idle and drops m_tvalid.
`timescale 1ns / 1ps

module wide_unsigned_restoring_divider
    import wdiv_pkg::*;
#(
    parameter int unsigned OPERAND_BITS = 96
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dividend_low[63:0], dividend_high[95:64], divisor_low[159:96],
    // divisor_high[191:160]
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quotient_low[63:0], quotient_high[95:64], remainder_low[159:96],
    // remainder_high[191:160]
    output logic [191:0] m_tdata,
    // divide_by_zero[0]
    output logic [0:0]   m_tuser
);

    localparam int unsigned W  = OPERAND_BITS;
    localparam int unsigned CW = $clog2(OPERAND_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg,   cnt_next;
    logic          dz_reg,    dz_next;

    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
    logic [W-1:0]      num;
    logic [W-1:0]      den;
    logic              den_zero;
    logic              s_fire;
    logic              m_fire;
    step_ctrl_t        ctrl;
    logic [W-1:0]      quo;
    logic [W-1:0]      rem;
    logic [WORD_W-1:0] quo_wide;
    logic [WORD_W-1:0] rem_wide;

    // Operands trimmed to the configured width.
    assign dividend = s_tdata[WORD_W-1:0];
    assign divisor  = s_tdata[2*WORD_W-1:WORD_W];
    assign num      = dividend[W-1:0];
    assign den      = divisor[W-1:0];
    assign den_zero = (den == '0);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);
    assign s_fire   = s_tvalid & s_tready;
    assign m_fire   = m_tvalid & m_tready;

    // Sequencer: load, count down the restoring steps, hold the result.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        dz_next     = dz_reg;
        ctrl.load   = 1'b0;
        ctrl.bypass = den_zero;
        ctrl.step   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ctrl.load = 1'b1;
                    dz_next   = den_zero;
                    cnt_next  = CW'(OPERAND_BITS);
                    state_next = den_zero ? ST_DONE : ST_BUSY;
                end
            end
            ST_BUSY: begin
                ctrl.step = 1'b1;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (m_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        dz_reg <= dz_next;
    end

    wdiv_unit #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_unit (
        .aclk (aclk),
        .ctrl (ctrl),
        .num  (num),
        .den  (den),
        .quo  (quo),
        .rem  (rem)
    );

    // Result word, widened back to the full field layout.
    assign quo_wide   = WORD_W'(quo);
    assign rem_wide   = WORD_W'(rem);
    assign m_tdata    = {rem_wide, quo_wide};
    assign m_tuser[0] = dz_reg;

endmodule

// ----- rtl/wdiv_checker.sv -----
// Port-level checks on the divider, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wdiv_port_checks (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // A result that is not taken stays offered.
    `ASSERT_CLK_RSTN(a_result_held, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid,
        "result dropped while stalled")

    // Taking a word makes the block busy for the following cycle.
    `ASSERT_CLK_RSTN(a_busy_after_take, aclk, aresetn,
        s_tvalid && s_tready |=> !s_tready,
        "ready after accepting a word")

    // Only one division is in flight: no new word while a result waits.
    `ASSERT_CLK_RSTN(a_one_in_flight, aclk, aresetn,
        m_tvalid |-> !s_tready,
        "ready while a result is pending")

    // A divide-by-zero result carries a zero quotient.
    `ASSERT_CLK_RSTN(a_dz_quotient, aclk, aresetn,
        m_tvalid && m_tuser[0] |-> m_tdata[95:0] == 96'd0,
        "nonzero quotient on divide by zero")

endmodule

bind wide_unsigned_restoring_divider wdiv_port_checks u_wdiv_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
